/* src/sigrrip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sigrrip_pkg
// shared sizes, record types and memory port bundle for the signature rrip
// replacement block
// ----------------------------------------------------------------------------
package sigrrip_pkg;

  localparam int NUM_SETS    = 2048;
  localparam int NUM_WAYS    = 16;
  localparam int SIG_ENTRIES = 256;
  localparam int SIG_BITS    = 12;

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int WAY_W   = $clog2(NUM_WAYS);
  localparam int ENT_W   = $clog2(SIG_ENTRIES);
  localparam int FILL_W  = $clog2(SIG_ENTRIES + 1);
  localparam int AGE_W   = 2;
  localparam int CNT_W   = 16;
  localparam int SADDR_W = SET_W + ENT_W;

  localparam logic [AGE_W-1:0] MAX_AGE = 2'd3;

  localparam logic [1:0] CFG_REUSE_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_REUSE_AGE       = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_AGE     = 2'd2;

  localparam logic MODE_VICTIM = 1'b0;

  typedef struct packed {
    logic [NUM_WAYS*AGE_W-1:0] ages;
    logic [FILL_W-1:0]         fill;
    logic [ENT_W-1:0]          oldest;
  } set_rec_t;

  typedef struct packed {
    logic [SIG_BITS-1:0] tag;
    logic [CNT_W-1:0]    hits;
    logic [CNT_W-1:0]    accesses;
  } sig_rec_t;

  typedef struct packed {
    logic               rd_en;
    logic [SADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [SADDR_W-1:0] wr_addr;
    sig_rec_t           wdata;
  } sig_req_t;

endpackage
`default_nettype wire

/* src/sigrrip_sig_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sigrrip_sig_ram
// signature store: tag, hit and access counters for every fifo slot of
// every set, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sigrrip_sig_ram (
  input  wire                        clk,
  input  wire sigrrip_pkg::sig_req_t req,
  output sigrrip_pkg::sig_rec_t      rdata
);
  import sigrrip_pkg::*;

  sig_rec_t mem [NUM_SETS*SIG_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/signature_rrip_replacement_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signature_rrip_replacement_top
// srrip replacement with a per-set pc signature fifo; set state and
// signature entries live in synchronous memories
// ----------------------------------------------------------------------------
//  port group  | direction | handshake            | contents
//  input       | in        | in_valid / in_ready  | mode set_index way pc_signature hit
//  output      | out       | out_valid / out_ready| victim_way
//  config      | in        | cfg_we               | cfg_index cfg_data
//
//  victim request: accept with set read issued, then age and write back
//  update: accept with set read issued, compare signature slots one per cycle
//  through the signature memory read port, then write back
//  after reset a clearing pass over all 2048 sets of the set memory holds in_ready low
//  a victim waits in its set-read step while the output register is full
// ----------------------------------------------------------------------------
module signature_rrip_replacement_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        mode,
  input  wire [10:0] set_index,
  input  wire [3:0]  way,
  input  wire [11:0] pc_signature,
  input  wire        hit,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [3:0] victim_way,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [15:0] cfg_data
);
  import sigrrip_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SETRD = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;

  logic [2:0] state;

  logic [CNT_W-1:0] reuse_threshold;
  logic [AGE_W-1:0] reuse_age;
  logic [AGE_W-1:0] default_age;

  // latched transaction
  logic                req_mode;
  logic [SET_W-1:0]    req_set;
  logic [WAY_W-1:0]    req_way;
  logic [SIG_BITS-1:0] req_sig;
  logic                req_hit;

  logic [SET_W-1:0] clr_idx;
  logic [ENT_W-1:0] scan_idx;
  logic             found;
  logic [ENT_W-1:0] found_slot;
  sig_rec_t         found_ent;

  set_rec_t set_mem [NUM_SETS];
  set_rec_t set_q;
  logic             set_rd_en;
  logic             set_wr_en;
  logic [SET_W-1:0] set_wr_addr;
  set_rec_t         set_wdata;

  sig_req_t sig_req;
  sig_rec_t sig_q;

  logic in_fire;
  logic out_free;
  logic vic_done;

  // victim selection
  logic [AGE_W-1:0] max_age;
  logic [AGE_W-1:0] bump;
  logic [WAY_W-1:0] vic_sel;
  logic [NUM_WAYS*AGE_W-1:0] aged;

  // write-back values
  sig_rec_t         base_ent;
  sig_rec_t         new_ent;
  logic [AGE_W-1:0] new_age;
  logic             full;
  logic [ENT_W-1:0] wb_slot;
  set_rec_t         wb_set;
  logic             scan_match;
  logic             scan_last;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign vic_done = (state == S_SETRD) && (req_mode == MODE_VICTIM) && out_free;

  assign scan_match = (sig_q.tag == req_sig);
  assign scan_last  = ({1'b0, scan_idx} + FILL_W'(1)) == set_q.fill;

  always_comb begin
    max_age = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (set_q.ages[w*AGE_W +: AGE_W] > max_age) begin
        max_age = set_q.ages[w*AGE_W +: AGE_W];
      end
    end
    bump = MAX_AGE - max_age;
    vic_sel = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (set_q.ages[w*AGE_W +: AGE_W] == max_age) begin
        vic_sel = WAY_W'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[w*AGE_W +: AGE_W] = set_q.ages[w*AGE_W +: AGE_W] + bump;
    end
  end

  always_comb begin
    full = (set_q.fill == FILL_W'(SIG_ENTRIES));
    if (found) begin
      base_ent = found_ent;
      wb_slot  = found_slot;
    end else begin
      base_ent = '{tag: req_sig, hits: '0, accesses: '0};
      wb_slot  = full ? set_q.oldest : set_q.fill[ENT_W-1:0];
    end
    new_ent          = base_ent;
    new_ent.accesses = base_ent.accesses + CNT_W'(1);
    new_ent.hits     = base_ent.hits + CNT_W'(req_hit);
    if (req_hit) begin
      new_age = '0;
    end else if (new_ent.hits >= reuse_threshold && new_ent.accesses > reuse_threshold) begin
      new_age = reuse_age;
    end else begin
      new_age = default_age;
    end
    wb_set = set_q;
    wb_set.ages[req_way*AGE_W +: AGE_W] = new_age;
    if (!found) begin
      if (full) begin
        wb_set.oldest = set_q.oldest + ENT_W'(1);
      end else begin
        wb_set.fill = set_q.fill + FILL_W'(1);
      end
    end
  end

  // set memory port control
  always_comb begin
    set_rd_en   = in_fire;
    set_wr_en   = 1'b0;
    set_wr_addr = req_set;
    set_wdata   = wb_set;
    case (state)
      S_CLEAR: begin
        set_wr_en   = 1'b1;
        set_wr_addr = clr_idx;
        set_wdata   = '{ages: {NUM_WAYS{MAX_AGE}}, fill: '0, oldest: '0};
      end
      S_SETRD: begin
        if (vic_done) begin
          set_wr_en = 1'b1;
          set_wdata = '{ages: aged, fill: set_q.fill, oldest: set_q.oldest};
        end
      end
      S_WB: begin
        set_wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (set_wr_en) begin
      set_mem[set_wr_addr] <= set_wdata;
    end
    if (set_rd_en) begin
      set_q <= set_mem[set_index];
    end
  end

  // signature memory port control
  always_comb begin
    sig_req.rd_en   = 1'b0;
    sig_req.rd_addr = {req_set, scan_idx + ENT_W'(1)};
    sig_req.wr_en   = (state == S_WB);
    sig_req.wr_addr = {req_set, wb_slot};
    sig_req.wdata   = new_ent;
    case (state)
      S_SETRD: begin
        sig_req.rd_en   = (req_mode != MODE_VICTIM) && (set_q.fill != '0);
        sig_req.rd_addr = {req_set, ENT_W'(0)};
      end
      S_SCAN: begin
        sig_req.rd_en = !scan_match && !scan_last;
      end
      default: begin
      end
    endcase
  end

  sigrrip_sig_ram u_sig_ram (
    .clk  (clk),
    .req  (sig_req),
    .rdata(sig_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_idx         <= '0;
      out_valid       <= 1'b0;
      reuse_threshold <= CNT_W'(4);
      reuse_age       <= AGE_W'(1);
      default_age     <= AGE_W'(3);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REUSE_THRESHOLD: reuse_threshold <= cfg_data;
          CFG_REUSE_AGE:       reuse_age       <= cfg_data[AGE_W-1:0];
          CFG_DEFAULT_AGE:     default_age     <= cfg_data[AGE_W-1:0];
          default: begin
          end
        endcase
      end
      if (vic_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + SET_W'(1);
          if (clr_idx == SET_W'(NUM_SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state <= S_SETRD;
          end
        end
        S_SETRD: begin
          if (req_mode == MODE_VICTIM) begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end else if (set_q.fill == '0) begin
            state <= S_WB;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_match || scan_last) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_mode <= mode;
      req_set  <= set_index;
      req_way  <= way;
      req_sig  <= pc_signature[SIG_BITS-1:0];
      req_hit  <= hit;
    end
    if (vic_done) begin
      victim_way <= vic_sel;
    end
    if (state == S_SETRD) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (state == S_SCAN) begin
      if (scan_match) begin
        found      <= 1'b1;
        found_slot <= scan_idx;
        found_ent  <= sig_q;
      end else begin
        scan_idx <= scan_idx + ENT_W'(1);
      end
    end
  end

  // scan never runs past the filled part of the fifo
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ({1'b0, scan_idx} < set_q.fill))
    else $error("signature scan beyond fill");

  // no transaction is taken while the set memory is being cleared
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("input accepted during clear");

  // a finished victim request shows up on the output next cycle
  assert property (@(posedge clk) disable iff (rst)
    vic_done |=> out_valid)
    else $error("victim result lost");

  // the signature store is written only for update requests, never for a victim request
  assert property (@(posedge clk) disable iff (rst)
    sig_req.wr_en |-> (req_mode != MODE_VICTIM))
    else $error("signature write on victim request");

endmodule
`default_nettype wire
